// ===== rtl/core/bblur_pkg.sv =====
// ---------------------------------------------------------------------------
// bblur_pkg
// Shared types and constants for the 3x3 RGB box blur core.
// ---------------------------------------------------------------------------
`default_nettype none

package bblur_pkg;

    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int WCFG_W     = 11;
    localparam int ROW_W      = 16;
    localparam int SUM_W      = 12;
    localparam int NUM_W      = SUM_W + 1;
    localparam int CNT_W      = 4;
    localparam int RECIP_W    = 20;
    localparam int RECIP_SH   = 20;
    localparam int PROD_W     = NUM_W + RECIP_W;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WCFG_W-1:0] WIDTH_RST  = 11'd1024;
    localparam logic [ROW_W-1:0]  HEIGHT_RST = 16'd768;

    typedef struct packed {
        logic accept;
        logic shift;
        logic sum;
        logic load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic drop;
        logic emit;
        logic out_free;
    } t_ctrl_sts;

    // ceil(2^20 / (2*count)); exact rounding divide for numerators below 2^13
    function automatic logic [RECIP_W-1:0] f_recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        unique case (cnt)
            4'd1:    m = 20'd524288;
            4'd2:    m = 20'd262144;
            4'd3:    m = 20'd174763;
            4'd4:    m = 20'd131072;
            4'd6:    m = 20'd87382;
            4'd9:    m = 20'd58255;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bblur_ctrl.sv =====
// ---------------------------------------------------------------------------
// bblur_ctrl
// Sequencer: input beat and window update, then, when a result is due, neighbourhood sum, divide and load.
// ---------------------------------------------------------------------------
`default_nettype none

module bblur_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_tvalid,
    output logic                  o_s_tready,
    output bblur_pkg::t_ctrl_cmd  o_cmd,
    input  bblur_pkg::t_ctrl_sts  i_sts
);

    typedef enum logic [1:0] {
        S_IN,
        S_RD,
        S_SUM,
        S_DIV
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_tready   = (r_state == S_IN);
    assign o_cmd.accept = (r_state == S_IN) && i_s_tvalid;
    assign o_cmd.shift  = (r_state == S_RD);
    assign o_cmd.sum    = (r_state == S_SUM);
    assign o_cmd.load   = (r_state == S_DIV) && i_sts.out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IN: begin
                if (i_s_tvalid && !i_sts.drop) n_state = S_RD;
            end
            S_RD: begin
                n_state = i_sts.emit ? S_SUM : S_IN;
            end
            S_SUM: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.out_free) n_state = S_IN;
            end
            default: n_state = S_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bblur_dp.sv =====
// ---------------------------------------------------------------------------
// bblur_dp
// Datapath: config registers, line store, 3x3 window, counters, rounding
// divide and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module bblur_dp #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_cfg_valid,
    input  wire  [bblur_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [bblur_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire  [bblur_pkg::PIX_W-1:0]            i_s_tdata,
    input  wire                                    i_s_tuser,
    output logic [bblur_pkg::PIX_W-1:0]            o_m_tdata,
    output logic                                   o_m_tlast,
    output logic                                   o_m_tvalid,
    input  wire                                    i_m_tready,
    input  bblur_pkg::t_ctrl_cmd                   i_cmd,
    output bblur_pkg::t_ctrl_sts                   o_sts
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = CW + 1;
    localparam int PW   = bblur_pkg::PIX_W;
    localparam int CHW  = bblur_pkg::CH_W;
    localparam int RW   = bblur_pkg::ROW_W;

    logic [bblur_pkg::WCFG_W-1:0] r_cfg_width;
    logic [RW-1:0]                r_cfg_height;
    logic [WW-1:0]                r_frame_w;
    logic [RW-1:0]                r_frame_h;
    logic [CW-1:0]                r_in_col;
    logic [RW:0]                  r_in_row;
    logic [CW-1:0]                r_out_col;
    logic [RW-1:0]                r_out_row;
    logic [2*PW-1:0]              r_lines [MAX_WIDTH];
    logic [2*PW-1:0]              r_rd;
    logic [PW-1:0]                r_pix;
    logic [PW-1:0]                r_win [3][3];
    logic [bblur_pkg::NUM_W-1:0]  r_num [3];
    logic [bblur_pkg::CNT_W-1:0]  r_cnt;
    logic                         r_last;
    logic [PW-1:0]                r_out_data;
    logic                         r_out_last;
    logic                         r_out_valid;

    logic [WW-1:0]                w_clamp;
    logic [RW-1:0]                h_clamp;
    logic                         at_start;
    logic [RW-1:0]                eff_h;
    logic                         pixel_phase;
    logic                         in_col_last;
    logic                         col_first;
    logic                         col_lastp;
    logic                         row_first;
    logic                         row_lastp;
    logic [bblur_pkg::SUM_W-1:0]  sum [3];
    logic [bblur_pkg::CNT_W-1:0]  cnt;
    logic [bblur_pkg::NUM_W-1:0]  num [3];
    logic [bblur_pkg::RECIP_W-1:0] recip;
    logic [bblur_pkg::PROD_W-1:0] prod [3];
    logic [PW-1:0]                quot;

    // frame size clamping
    always_comb begin
        if (r_cfg_width == '0) begin
            w_clamp = WW'(1);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            w_clamp = WW'(MAX_WIDTH);
        end else begin
            w_clamp = WW'(r_cfg_width);
        end
        h_clamp = (r_cfg_height == '0) ? RW'(1) : r_cfg_height;
    end

    assign at_start    = (r_in_col == '0) && (r_in_row == '0)
                      && (r_out_col == '0) && (r_out_row == '0);
    assign eff_h       = at_start ? h_clamp : r_frame_h;
    assign pixel_phase = r_in_row < {1'b0, eff_h};
    assign in_col_last = ({1'b0, r_in_col} + WW'(1)) == r_frame_w;

    assign col_first = (r_out_col == '0);
    assign col_lastp = ({1'b0, r_out_col} + WW'(1)) == r_frame_w;
    assign row_first = (r_out_row == '0);
    assign row_lastp = ({1'b0, r_out_row} + (RW+1)'(1)) == {1'b0, r_frame_h};

    assign o_sts.drop     = pixel_phase && i_s_tuser;
    assign o_sts.emit     = (r_in_row >= (RW+1)'(2))
                         || ((r_in_row == (RW+1)'(1)) && (r_in_col != '0));
    assign o_sts.out_free = !r_out_valid || i_m_tready;

    // masked 3x3 sum per channel
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = '0;
        end
        cnt = '0;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                if (!(c == 0 && col_first) && !(c == 2 && col_lastp)
                    && !(r == 0 && row_first) && !(r == 2 && row_lastp)) begin
                    for (int ch = 0; ch < 3; ch++) begin
                        sum[ch] = sum[ch]
                                + bblur_pkg::SUM_W'(r_win[c][r][ch*CHW +: CHW]);
                    end
                    cnt = cnt + bblur_pkg::CNT_W'(1);
                end
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            num[ch] = {sum[ch], 1'b0} + bblur_pkg::NUM_W'(cnt);
        end
    end

    // rounding divide by reciprocal multiply
    assign recip = bblur_pkg::f_recip(r_cnt);
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = bblur_pkg::PROD_W'(r_num[ch]) * bblur_pkg::PROD_W'(recip);
            quot[ch*CHW +: CHW] = prod[ch][bblur_pkg::RECIP_SH +: CHW];
        end
    end

    // line store: upper row in the high half, middle row in the low half
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !o_sts.drop) begin
            r_rd <= r_lines[r_in_col];
        end
        if (i_cmd.shift) begin
            r_lines[r_in_col] <= {r_rd[PW-1:0], r_pix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !o_sts.drop) begin
            r_pix <= pixel_phase ? i_s_tdata : '0;
        end
        if (i_cmd.sum) begin
            r_num  <= num;
            r_cnt  <= cnt;
            r_last <= row_lastp && col_lastp;
        end
        if (i_cmd.load) begin
            r_out_data <= quot;
            r_out_last <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= bblur_pkg::WIDTH_RST;
            r_cfg_height <= bblur_pkg::HEIGHT_RST;
            r_frame_w    <= WW'(MAX_WIDTH);
            r_frame_h    <= bblur_pkg::HEIGHT_RST;
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
            r_out_valid  <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[c][r] <= '0;
                end
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    bblur_pkg::CFG_IMAGE_WIDTH:
                        r_cfg_width <= i_cfg_data[bblur_pkg::WCFG_W-1:0];
                    bblur_pkg::CFG_IMAGE_HEIGHT:
                        r_cfg_height <= i_cfg_data[RW-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.accept && at_start) begin
                r_frame_w <= w_clamp;
                r_frame_h <= h_clamp;
            end

            if (i_cmd.shift) begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2][0] <= r_rd[2*PW-1:PW];
                r_win[2][1] <= r_rd[PW-1:0];
                r_win[2][2] <= r_pix;
                if (in_col_last) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + (RW+1)'(1);
                end else begin
                    r_in_col <= r_in_col + CW'(1);
                end
            end

            if (i_cmd.sum) begin
                if (row_lastp && col_lastp) begin
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                end else if (col_lastp) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + RW'(1);
                end else begin
                    r_out_col <= r_out_col + CW'(1);
                end
            end

            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tvalid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/core/box_blur_3x3_rgb_core.sv =====
// Each result passes through the window shift, the registered sum and the
// output register, which loads once the output is free (results trail the
// input by width+1 beats). A new beat is taken only once the previous one
// has left the sequence; ignored flush beats leave it in its input state.
// Reset: synchronous, active low; counters, window, output valid and config
// (1024 x 768) are cleared; the line store is not cleared and needs no pass.
// ---------------------------------------------------------------------------
// box_blur_3x3_rgb_core
// Streaming 3x3 box blur with edge-normalised rounding on 24-bit RGB pixels.
// ---------------------------------------------------------------------------
`default_nettype none

module box_blur_3x3_rgb_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // config write channel: index 0 = image_width, 1 = image_height
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [bblur_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [bblur_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                               i_s_tvalid,
    output logic                              o_s_tready,
    input  wire  [bblur_pkg::PIX_W-1:0]       i_s_tdata,  // red_in, green_in, blue_in
    input  wire                               i_s_tuser,  // cmd
    output logic                              o_m_tvalid,
    input  wire                               i_m_tready,
    output logic [bblur_pkg::PIX_W-1:0]       o_m_tdata,  // red_out, green_out, blue_out
    output logic                              o_m_tlast   // frame_last
);

    bblur_pkg::t_ctrl_cmd cmd;
    bblur_pkg::t_ctrl_sts sts;

    assign o_cfg_ready = 1'b1;

    bblur_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    bblur_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

`default_nettype wire

// ===== rtl/core/bblur_chk.sv =====
// ---------------------------------------------------------------------------
// bblur_chk
// Port-level checks for the box blur core, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module bblur_chk (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_s_tvalid,
    input wire                          o_s_tready,
    input wire                          o_m_tvalid,
    input wire                          i_m_tready,
    input wire [bblur_pkg::PIX_W-1:0]   o_m_tdata,
    input wire                          o_m_tlast
);

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled output beat changed");

    a_no_fast_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !$rose(o_m_tvalid))
        else $error("result one cycle after input beat");

    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !$past(o_s_tready))
        else $error("result loaded while input side was open");

endmodule

bind box_blur_3x3_rgb_core bblur_chk u_bblur_chk (.*);

`default_nettype wire

// ===== tb/box_blur_3x3_rgb_core_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// box_blur_3x3_rgb_core_checker
// Watches the config, pixel and result channels of the box blur core. It
// keeps its own copy of the line stores, the 3x3 window, the frame counters
// and the config registers, works out the blurred pixel expected from each
// accepted beat that completes a neighbourhood, and compares each result beat
// field by field with the oldest one still outstanding.
// ---------------------------------------------------------------------------
module box_blur_3x3_rgb_core_checker #(
    parameter int MAX_W = 1024
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_valid,
    input  wire                              i_cfg_ready,
    input  wire [bblur_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [bblur_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                              i_s_tvalid,
    input  wire                              i_s_tready,
    input  wire [bblur_pkg::PIX_W-1:0]       i_s_tdata,  // red_in, green_in, blue_in
    input  wire                              i_s_tuser,  // cmd
    input  wire                              i_m_tvalid,
    input  wire                              i_m_tready,
    input  wire [bblur_pkg::PIX_W-1:0]       i_m_tdata,  // red_out, green_out, blue_out
    input  wire                              i_m_tlast,  // frame_last
    output int                               o_fail_count,
    output int                               o_pending
);

    typedef struct packed {
        logic [bblur_pkg::CH_W-1:0] red;
        logic [bblur_pkg::CH_W-1:0] green;
        logic [bblur_pkg::CH_W-1:0] blue;
        logic                       last;
    } t_blurred_px;

    logic [bblur_pkg::WCFG_W-1:0] cfg_width;
    logic [bblur_pkg::ROW_W-1:0]  cfg_height;
    int unsigned                  frame_w, frame_h;
    int unsigned                  in_row, in_col, out_row, out_col;
    logic [bblur_pkg::PIX_W-1:0]  upper_row  [MAX_W];
    logic [bblur_pkg::PIX_W-1:0]  middle_row [MAX_W];
    logic [bblur_pkg::PIX_W-1:0]  win [3][3];  // [column: left..right][row: top..bottom]
    t_blurred_px                  blurred_q [$];

    initial begin
        for (int i = 0; i < MAX_W; i++) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
    end

    function automatic void predict_beat(input logic cmd,
                                         input logic [bblur_pkg::PIX_W-1:0] px);
        int unsigned                 x, cnt, sum_r, sum_g, sum_b;
        logic [bblur_pkg::PIX_W-1:0] pin;
        bit                          emit;
        t_blurred_px                 res;
        if (in_row == 0 && in_col == 0 && out_row == 0 && out_col == 0) begin
            frame_w = (cfg_width == 0) ? 1 : (cfg_width > MAX_W) ? MAX_W : cfg_width;
            frame_h = (cfg_height == 0) ? 1 : cfg_height;
        end
        // flush beat while pixels are still due: dropped
        if (in_row < frame_h && cmd) return;
        pin = (in_row < frame_h) ? px : '0;
        x = in_col % MAX_W;
        for (int r = 0; r < 3; r++) begin
            win[0][r] = win[1][r];
            win[1][r] = win[2][r];
        end
        win[2][0] = upper_row[x];
        win[2][1] = middle_row[x];
        win[2][2] = pin;
        upper_row[x]  = middle_row[x];
        middle_row[x] = pin;
        emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
        in_col++;
        if (in_col >= frame_w) begin
            in_col = 0;
            in_row++;
        end
        if (!emit) return;
        cnt = 0;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                if ((c == 0 && out_col == 0) || (c == 2 && out_col + 1 >= frame_w) ||
                    (r == 0 && out_row == 0) || (r == 2 && out_row + 1 >= frame_h))
                    continue;
                sum_r += win[c][r][7:0];
                sum_g += win[c][r][15:8];
                sum_b += win[c][r][23:16];
                cnt++;
            end
        end
        res.red   = bblur_pkg::CH_W'((2 * sum_r + cnt) / (2 * cnt));
        res.green = bblur_pkg::CH_W'((2 * sum_g + cnt) / (2 * cnt));
        res.blue  = bblur_pkg::CH_W'((2 * sum_b + cnt) / (2 * cnt));
        res.last  = (out_row + 1 >= frame_h) && (out_col + 1 >= frame_w);
        blurred_q.push_back(res);
        if (res.last) begin
            in_row  = 0;
            in_col  = 0;
            out_row = 0;
            out_col = 0;
        end else begin
            out_col++;
            if (out_col >= frame_w) begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    function automatic int field_miss(input string name, input logic [7:0] expv,
                                      input logic [7:0] actv);
        if (actv !== expv) begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_blurred_px want;
        if (!i_rst_n) begin
            cfg_width  = bblur_pkg::WIDTH_RST;
            cfg_height = bblur_pkg::HEIGHT_RST;
            frame_w = 1;
            frame_h = 1;
            in_row  = 0;
            in_col  = 0;
            out_row = 0;
            out_col = 0;
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) win[c][r] = '0;
            end
            blurred_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (blurred_q.size() == 0) begin
                    $error("result beat with nothing outstanding: tdata=%h tlast=%b",
                           i_m_tdata, i_m_tlast);
                    o_fail_count++;
                end else begin
                    want = blurred_q.pop_front();
                    o_fail_count += field_miss("red_out", want.red, i_m_tdata[7:0]);
                    o_fail_count += field_miss("green_out", want.green, i_m_tdata[15:8]);
                    o_fail_count += field_miss("blue_out", want.blue, i_m_tdata[23:16]);
                    o_fail_count += field_miss("frame_last", {7'd0, want.last},
                                               {7'd0, i_m_tlast});
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == bblur_pkg::CFG_IMAGE_WIDTH)
                    cfg_width = i_cfg_data[bblur_pkg::WCFG_W-1:0];
                else if (i_cfg_index == bblur_pkg::CFG_IMAGE_HEIGHT)
                    cfg_height = i_cfg_data[bblur_pkg::ROW_W-1:0];
            end
            if (i_s_tvalid && i_s_tready)
                predict_beat(i_s_tuser, i_s_tdata);
        end
        o_pending = blurred_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Stimulus for the 3x3 RGB box blur core: a directed opening on corner pixel
// values, degenerate frame sizes, the largest register values, dropped flush
// and pixel beats and a config change mid-frame, then one frame under a long
// receiver hold-off and a long run of small random frames. Sender bursts and
// receiver stall patterns vary the timing; the checker does the comparison.
// ---------------------------------------------------------------------------
module testbench;

    localparam int MAX_W          = 1024;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_STARVED} t_rx_mode;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic [bblur_pkg::CFG_IDX_W-1:0]  cfg_index = bblur_pkg::CFG_IMAGE_WIDTH;
    logic [bblur_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                             s_tvalid = 1'b0;
    logic [bblur_pkg::PIX_W-1:0]      s_tdata = '0;
    logic                             s_tuser = 1'b0;
    logic                             m_tready = 1'b0;
    wire                              o_cfg_ready, o_s_tready, o_m_tvalid, o_m_tlast;
    wire  [bblur_pkg::PIX_W-1:0]      o_m_tdata;
    int                               fails, pending;
    int unsigned                      burst_left = 0;
    int unsigned                      idle_cycles = 0;
    bit                               hold_req = 1'b0;

    logic [bblur_pkg::PIX_W-1:0] probe_px [9] = '{24'h000000, 24'hFFFFFF, 24'h0000FF,
                                                  24'h00FF00, 24'hFF0000, 24'hFFFFFF,
                                                  24'h000000, 24'h5AA5C3, 24'hFFFFFF};

    always #5 i_clk = ~i_clk;

    box_blur_3x3_rgb_core #(.MAX_WIDTH(MAX_W)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    box_blur_3x3_rgb_core_checker #(.MAX_W(MAX_W)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tlast    (o_m_tlast),
        .o_fail_count (fails),
        .o_pending    (pending)
    );

    // watchdog: cycles without any beat on any channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready) ||
                (cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[box_blur_3x3_rgb_core] ERROR");
                $finish;
            end
        end
    end

    // receiver: stall patterns, plus a long hold-off on request
    initial begin
        t_rx_mode    rx_mode;
        int unsigned mode_left, tick;
        rx_mode = RX_OPEN;
        mode_left = 0;
        tick = 0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 200);
                end
                mode_left--;
                case (rx_mode)
                    RX_OPEN:    m_tready <= 1'b1;
                    RX_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
                    RX_PATTERN: m_tready <= ((tick % 7) < 3);
                    default:    m_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    function automatic logic [bblur_pkg::CH_W-1:0] rand_channel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return bblur_pkg::CH_W'($urandom);
        endcase
    endfunction

    function automatic logic [bblur_pkg::PIX_W-1:0] rand_px();
        return {rand_channel(), rand_channel(), rand_channel()};
    endfunction

    // valid stays high after a beat; callers that wait lower it first
    task automatic send_beat(input logic cmd, input logic [bblur_pkg::PIX_W-1:0] px);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= px;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [bblur_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bblur_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // one frame of pixels and its flush; a rough frame cuts the flush short
    task automatic send_frame(input int unsigned fw, input int unsigned fh, input bit rough);
        int unsigned n_flush;
        for (int unsigned p = 0; p < fw * fh; p++) begin
            if ($urandom_range(0, 19) == 0) send_beat(1'b1, bblur_pkg::PIX_W'($urandom));
            send_beat(1'b0, rand_px());
        end
        n_flush = rough ? $urandom_range(0, fw) : fw + 1;
        for (int unsigned f = 0; f < n_flush; f++)
            send_beat($urandom_range(0, 4) != 0, bblur_pkg::PIX_W'($urandom));
    endtask

    initial begin
        int unsigned                      sent, frame_no, w_reg, h_reg, fw, fh;
        logic [bblur_pkg::CFG_DATA_W-1:0] wdata;
        sent = 0;
        frame_no = 0;
        w_reg = 0;
        h_reg = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // 3x3 frame of corner values; size change mid-frame applies to the next one
        cfg_write(bblur_pkg::CFG_IMAGE_WIDTH, 16'd3);
        cfg_write(bblur_pkg::CFG_IMAGE_HEIGHT, 16'd3);
        for (int i = 0; i < 9; i++) begin
            send_beat(1'b0, probe_px[i]);
            if (i == 1) send_beat(1'b1, 24'hFFFFFF);
            if (i == 3) begin
                wait_idle();
                cfg_write(bblur_pkg::CFG_IMAGE_WIDTH, 16'hF800);
                cfg_write(bblur_pkg::CFG_IMAGE_HEIGHT, 16'h0000);
            end
        end
        send_beat(1'b1, 24'h000000);
        send_beat(1'b0, 24'hA5C33C);
        send_beat(1'b1, 24'h000000);
        send_beat(1'b1, 24'hFFFFFF);

        // 1x1 frame, with the largest register values written before it ends
        send_beat(1'b0, 24'hFFFFFF);
        send_beat(1'b1, 24'h000000);
        wait_idle();
        cfg_write(bblur_pkg::CFG_IMAGE_WIDTH, 16'h07FF);
        cfg_write(bblur_pkg::CFG_IMAGE_HEIGHT, 16'hFFFF);
        send_beat(1'b1, 24'h000000);
        wait_idle();
        cfg_write(bblur_pkg::CFG_IMAGE_WIDTH, 16'd20);
        cfg_write(bblur_pkg::CFG_IMAGE_HEIGHT, 16'd2);

        // 20x2 frame, with the receiver held off early on
        hold_req = 1'b1;
        send_frame(20, 2, 1'b0);

        while (sent < RANDOM_ITEMS) begin
            if (frame_no == 4) hold_req = 1'b1;
            if (frame_no == 0 || $urandom_range(0, 2) == 0) begin
                wait_idle();
                if (frame_no == 0 || $urandom_range(0, 3) != 0) begin
                    case ($urandom_range(0, 9))
                        0:       w_reg = 0;
                        1, 2, 3: w_reg = $urandom_range(1, 3);
                        4, 5, 6: w_reg = $urandom_range(4, 12);
                        default: w_reg = $urandom_range(13, 40);
                    endcase
                    wdata = bblur_pkg::CFG_DATA_W'($urandom);
                    wdata[bblur_pkg::WCFG_W-1:0] = bblur_pkg::WCFG_W'(w_reg);
                    cfg_write(bblur_pkg::CFG_IMAGE_WIDTH, wdata);
                end
                if (frame_no == 0 || $urandom_range(0, 3) != 0) begin
                    case ($urandom_range(0, 9))
                        0:       h_reg = 0;
                        1:       h_reg = $urandom_range(6, 10);
                        default: h_reg = $urandom_range(1, 5);
                    endcase
                    if (w_reg > 12 && h_reg > 4) h_reg = 4;
                    cfg_write(bblur_pkg::CFG_IMAGE_HEIGHT, bblur_pkg::CFG_DATA_W'(h_reg));
                end
            end
            fw = (w_reg == 0) ? 1 : w_reg;
            fh = (h_reg == 0) ? 1 : h_reg;
            send_frame(fw, fh, $urandom_range(0, 11) == 0);
            sent += fw * fh + fw + 1;
            frame_no++;
        end

        wait_idle();
        if (fails == 0 && pending == 0)
            $display("[box_blur_3x3_rgb_core] OK");
        else
            $display("[box_blur_3x3_rgb_core] ERROR");
        $finish;
    end

endmodule
